// ===== hw/rtl/sva_pkg.sv =====
// types and constants shared by the voice allocator modules
`timescale 1ns / 1ps

package sva_pkg;

    localparam int NOTES       = 128;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int CMD_W       = 3;
    localparam int ACT_W       = 3;
    localparam int VIDX_W      = 5;
    localparam int STAMP_W     = 32;
    localparam int KEY_CNT_W   = 8;
    localparam int RES_CNT_W   = 6;
    localparam int MAX_RESULTS = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CMD_W-1:0] CMD_NOTE_ON    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_KILL       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEDAL_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEDAL_UP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_VOICE_DONE = 3'd5;

    localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RETRIG  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GLIDE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd5;

    localparam logic [VEL_W-1:0] FALLBACK_VEL = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_MONO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGATO = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } in_item_t;

    typedef struct packed {
        logic [VIDX_W-1:0] voice_index;
        logic [ACT_W-1:0]  action;
        logic [NOTE_W-1:0] out_note;
        logic [VEL_W-1:0]  out_velocity;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [NOTE_W-1:0]  note;
        logic [STAMP_W-1:0] stamp;
        logic               releasing;
    } voice_entry_t;

    typedef struct packed {
        logic accept;
        logic vscan_start;
        logic kscan_start;
        logic pedal_step;
        logic apply;
        logic push;
        logic push_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pedal;
        logic             vs_done;
        logic             ks_done;
        logic             need_kscan;
        logic             pend_valid;
        logic             cnt_full;
        logic             out_free;
        logic             kn_done;
        logic             sust_hit;
    } dp_status_t;

endpackage

// ===== hw/rtl/sva_datapath.sv =====
// voice and key state, scan units, result staging and output register
`timescale 1ns / 1ps

module sva_datapath #(
    parameter int VOICES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sva_pkg::ctrl_cmd_t              op,
    output sva_pkg::dp_status_t             status,
    input  sva_pkg::in_item_t               in_data,
    input  logic                            cfg_valid,
    input  logic [sva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_data,
    input  logic                            out_stall,
    output logic                            out_valid,
    output sva_pkg::out_item_t              out_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic mono_reg;
    logic legato_reg;

    logic [sva_pkg::CMD_W-1:0]     cmd_reg;
    logic [sva_pkg::NOTE_W-1:0]    note_reg;
    logic [sva_pkg::VEL_W-1:0]     vel_reg;
    logic [sva_pkg::NOTE_W-1:0]    tgt_reg;
    logic [sva_pkg::STAMP_W-1:0]   ec_reg;
    logic                          pedal_reg;
    logic                          another_reg;
    logic [sva_pkg::NOTES-1:0]     key_down_reg;
    logic [sva_pkg::NOTES-1:0]     key_sust_reg;
    logic [sva_pkg::KEY_CNT_W-1:0] kn_reg;
    logic [VOICES-1:0]             voice_valid_reg;

    // voice scan
    logic                        vs_run_reg;
    logic                        vs_rd_reg;
    logic [VW-1:0]               vi_reg;
    logic [VW-1:0]               vidx_d_reg;
    logic                        vv_d_reg;
    sva_pkg::voice_entry_t       vm_rd_reg;
    logic                        found_reg;
    logic [VW-1:0]               fidx_reg;
    logic [sva_pkg::NOTE_W-1:0]  fnote_reg;
    logic                        frel_reg;
    logic                        free_found_reg;
    logic [VW-1:0]               free_idx_reg;
    logic                        rel_found_reg;
    logic [VW-1:0]               rel_idx_reg;
    logic [sva_pkg::STAMP_W-1:0] rel_diff_reg;
    logic                        all_found_reg;
    logic [VW-1:0]               all_idx_reg;
    logic [sva_pkg::STAMP_W-1:0] all_diff_reg;
    logic                        v0_rel_reg;
    logic [sva_pkg::STAMP_W-1:0] vdiff;
    logic                        vmatch;

    // key scan
    logic                        ks_run_reg;
    logic                        ks_rd_reg;
    logic [sva_pkg::NOTE_W-1:0]  kk_reg;
    logic [sva_pkg::NOTE_W-1:0]  kidx_d_reg;
    logic                        kd_d_reg;
    logic [sva_pkg::STAMP_W-1:0] rec_rd_reg;
    logic                        best_found_reg;
    logic [sva_pkg::NOTE_W-1:0]  best_note_reg;
    logic [sva_pkg::STAMP_W-1:0] best_age_reg;
    logic [sva_pkg::STAMP_W-1:0] kage;

    // result staging
    logic                            pend_valid_reg;
    sva_pkg::out_item_t              pend_reg;
    logic [sva_pkg::RES_CNT_W-1:0]   cnt_reg;
    logic                            out_valid_reg;
    sva_pkg::out_item_t              out_reg;

    sva_pkg::voice_entry_t voice_mem [VOICES];
    logic [sva_pkg::STAMP_W-1:0] rec_mem [sva_pkg::NOTES];

    // apply decode
    logic                       mem_we;
    logic                       valid_set;
    logic                       valid_clr;
    logic [VW-1:0]              wv;
    sva_pkg::voice_entry_t      wentry;
    logic                       res_valid;
    sva_pkg::out_item_t         res;
    logic [sva_pkg::ACT_W-1:0]  act;
    logic                       glide;
    logic [VW-1:0]              steal_idx;

    logic vs_start;
    logic cnt_full;
    logic out_free;
    logic acc_note_on;

    assign cnt_full    = cnt_reg == sva_pkg::RES_CNT_W'(sva_pkg::MAX_RESULTS);
    assign out_free    = !out_valid_reg || !out_stall;
    assign acc_note_on = op.accept && in_data.command == sva_pkg::CMD_NOTE_ON;
    assign vs_start    = op.vscan_start
                         || (op.pedal_step && !kn_reg[sva_pkg::KEY_CNT_W-1]
                             && key_sust_reg[kn_reg[sva_pkg::NOTE_W-1:0]]);
    assign vdiff  = ec_reg - vm_rd_reg.stamp;
    assign vmatch = vv_d_reg && (mono_reg || vm_rd_reg.note == tgt_reg);
    assign kage   = ec_reg - rec_rd_reg;
    assign steal_idx = rel_found_reg ? rel_idx_reg : (all_found_reg ? all_idx_reg : '0);

    always_comb
    begin
        mem_we    = 1'b0;
        valid_set = 1'b0;
        valid_clr = 1'b0;
        wv        = fidx_reg;
        wentry    = '{note: fnote_reg, stamp: ec_reg, releasing: frel_reg};
        res_valid = 1'b0;
        res       = '0;
        act       = sva_pkg::ACT_START;
        glide     = 1'b0;
        case (cmd_reg)
            sva_pkg::CMD_NOTE_ON:
            begin
                if (mono_reg)
                begin
                    if (legato_reg && another_reg)
                        act = voice_valid_reg[0] ? sva_pkg::ACT_GLIDE : sva_pkg::ACT_START;
                    else
                        act = voice_valid_reg[0] ? sva_pkg::ACT_RESTART : sva_pkg::ACT_START;
                    glide     = act == sva_pkg::ACT_GLIDE;
                    wv        = '0;
                    wentry    = '{note: note_reg, stamp: ec_reg,
                                  releasing: glide ? v0_rel_reg : 1'b0};
                    mem_we    = 1'b1;
                    valid_set = 1'b1;
                    res_valid = 1'b1;
                    res       = '{voice_index: '0, action: act, out_note: note_reg,
                                  out_velocity: glide ? '0 : vel_reg, last_of_run: 1'b0};
                end
                else
                begin
                    if (found_reg)
                    begin
                        wv  = fidx_reg;
                        act = sva_pkg::ACT_RETRIG;
                    end
                    else if (free_found_reg)
                    begin
                        wv  = free_idx_reg;
                        act = sva_pkg::ACT_START;
                    end
                    else
                    begin
                        wv  = steal_idx;
                        act = sva_pkg::ACT_RESTART;
                    end
                    wentry    = '{note: note_reg, stamp: ec_reg, releasing: 1'b0};
                    mem_we    = 1'b1;
                    valid_set = 1'b1;
                    res_valid = 1'b1;
                    res       = '{voice_index: sva_pkg::VIDX_W'(wv), action: act,
                                  out_note: note_reg, out_velocity: vel_reg,
                                  last_of_run: 1'b0};
                end
            end
            sva_pkg::CMD_KILL, sva_pkg::CMD_VOICE_DONE:
            begin
                if (found_reg)
                begin
                    wentry    = '{note: fnote_reg, stamp: ec_reg, releasing: 1'b0};
                    mem_we    = 1'b1;
                    valid_clr = 1'b1;
                    res_valid = 1'b1;
                    res       = '{voice_index: sva_pkg::VIDX_W'(fidx_reg),
                                  action: sva_pkg::ACT_STOP, out_note: fnote_reg,
                                  out_velocity: '0, last_of_run: 1'b0};
                end
            end
            sva_pkg::CMD_NOTE_OFF, sva_pkg::CMD_PEDAL_UP:
            begin
                if (found_reg)
                begin
                    if (!mono_reg || !best_found_reg)
                    begin
                        wentry    = '{note: fnote_reg, stamp: ec_reg, releasing: 1'b1};
                        mem_we    = 1'b1;
                        res_valid = 1'b1;
                        res       = '{voice_index: sva_pkg::VIDX_W'(fidx_reg),
                                      action: sva_pkg::ACT_RELEASE, out_note: fnote_reg,
                                      out_velocity: '0, last_of_run: 1'b0};
                    end
                    else if (legato_reg)
                    begin
                        wentry    = '{note: best_note_reg, stamp: ec_reg, releasing: frel_reg};
                        mem_we    = 1'b1;
                        valid_set = 1'b1;
                        res_valid = 1'b1;
                        res       = '{voice_index: sva_pkg::VIDX_W'(fidx_reg),
                                      action: sva_pkg::ACT_GLIDE, out_note: best_note_reg,
                                      out_velocity: '0, last_of_run: 1'b0};
                    end
                    else if (best_note_reg != fnote_reg)
                    begin
                        wentry    = '{note: best_note_reg, stamp: ec_reg, releasing: 1'b0};
                        mem_we    = 1'b1;
                        valid_set = 1'b1;
                        res_valid = 1'b1;
                        res       = '{voice_index: sva_pkg::VIDX_W'(fidx_reg),
                                      action: sva_pkg::ACT_RESTART, out_note: best_note_reg,
                                      out_velocity: sva_pkg::FALLBACK_VEL,
                                      last_of_run: 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // voice and recency memories
    always_ff @(posedge clk)
    begin
        if (op.apply && mem_we)
            voice_mem[wv] <= wentry;
        if (vs_run_reg)
            vm_rd_reg <= voice_mem[vi_reg];
        if (acc_note_on)
            rec_mem[in_data.note] <= ec_reg + 1'b1;
        if (ks_run_reg)
            rec_rd_reg <= rec_mem[kk_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg        <= 1'b0;
            legato_reg      <= 1'b0;
            cmd_reg         <= '0;
            note_reg        <= '0;
            vel_reg         <= '0;
            tgt_reg         <= '0;
            ec_reg          <= '0;
            pedal_reg       <= 1'b0;
            another_reg     <= 1'b0;
            key_down_reg    <= '0;
            key_sust_reg    <= '0;
            kn_reg          <= '0;
            voice_valid_reg <= '0;
            vs_run_reg      <= 1'b0;
            vs_rd_reg       <= 1'b0;
            vi_reg          <= '0;
            vidx_d_reg      <= '0;
            vv_d_reg        <= 1'b0;
            found_reg       <= 1'b0;
            fidx_reg        <= '0;
            fnote_reg       <= '0;
            frel_reg        <= 1'b0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            rel_found_reg   <= 1'b0;
            rel_idx_reg     <= '0;
            rel_diff_reg    <= '0;
            all_found_reg   <= 1'b0;
            all_idx_reg     <= '0;
            all_diff_reg    <= '0;
            v0_rel_reg      <= 1'b0;
            ks_run_reg      <= 1'b0;
            ks_rd_reg       <= 1'b0;
            kk_reg          <= '0;
            kidx_d_reg      <= '0;
            kd_d_reg        <= 1'b0;
            best_found_reg  <= 1'b0;
            best_note_reg   <= '0;
            best_age_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sva_pkg::CFG_MONO:   mono_reg   <= cfg_data;
                    sva_pkg::CFG_LEGATO: legato_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // request intake and key state
            if (op.accept)
            begin
                cmd_reg  <= in_data.command;
                note_reg <= in_data.note;
                vel_reg  <= in_data.velocity;
                tgt_reg  <= in_data.note;
                kn_reg   <= '0;
                cnt_reg  <= '0;
                if (in_data.command <= sva_pkg::CMD_VOICE_DONE)
                    ec_reg <= ec_reg + 1'b1;
                case (in_data.command)
                    sva_pkg::CMD_NOTE_ON:
                    begin
                        another_reg                 <= |key_down_reg;
                        key_down_reg[in_data.note]  <= 1'b1;
                        key_sust_reg[in_data.note]  <= 1'b0;
                    end
                    sva_pkg::CMD_NOTE_OFF:
                    begin
                        if (pedal_reg && key_down_reg[in_data.note])
                            key_sust_reg[in_data.note] <= 1'b1;
                        key_down_reg[in_data.note] <= 1'b0;
                    end
                    sva_pkg::CMD_PEDAL_DOWN:
                        pedal_reg <= 1'b1;
                    default:
                    begin
                    end
                endcase
            end

            // pedal release walk
            if (op.pedal_step)
            begin
                if (kn_reg[sva_pkg::KEY_CNT_W-1])
                begin
                    key_sust_reg <= '0;
                    pedal_reg    <= 1'b0;
                end
                else
                begin
                    if (key_sust_reg[kn_reg[sva_pkg::NOTE_W-1:0]])
                        tgt_reg <= kn_reg[sva_pkg::NOTE_W-1:0];
                    kn_reg <= kn_reg + 1'b1;
                end
            end

            // voice scan
            if (vs_start)
            begin
                vi_reg         <= '0;
                vs_run_reg     <= 1'b1;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                rel_found_reg  <= 1'b0;
                rel_diff_reg   <= '0;
                all_found_reg  <= 1'b0;
                all_diff_reg   <= '0;
            end
            else if (vs_run_reg)
            begin
                if (vi_reg == VW'(VOICES - 1))
                    vs_run_reg <= 1'b0;
                else
                    vi_reg <= vi_reg + 1'b1;
            end
            vs_rd_reg  <= vs_run_reg;
            vv_d_reg   <= voice_valid_reg[vi_reg];
            vidx_d_reg <= vi_reg;
            if (vs_rd_reg)
            begin
                if (vmatch && !found_reg)
                begin
                    found_reg <= 1'b1;
                    fidx_reg  <= vidx_d_reg;
                    fnote_reg <= vm_rd_reg.note;
                    frel_reg  <= vm_rd_reg.releasing;
                end
                if (!vv_d_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= vidx_d_reg;
                end
                if (vm_rd_reg.releasing && vdiff > rel_diff_reg)
                begin
                    rel_found_reg <= 1'b1;
                    rel_idx_reg   <= vidx_d_reg;
                    rel_diff_reg  <= vdiff;
                end
                if (vdiff > all_diff_reg)
                begin
                    all_found_reg <= 1'b1;
                    all_idx_reg   <= vidx_d_reg;
                    all_diff_reg  <= vdiff;
                end
                if (vidx_d_reg == '0)
                    v0_rel_reg <= vm_rd_reg.releasing;
            end

            // held key scan
            if (op.kscan_start)
            begin
                kk_reg         <= '0;
                ks_run_reg     <= 1'b1;
                best_found_reg <= 1'b0;
            end
            else if (ks_run_reg)
            begin
                if (kk_reg == sva_pkg::NOTE_W'(sva_pkg::NOTES - 1))
                    ks_run_reg <= 1'b0;
                else
                    kk_reg <= kk_reg + 1'b1;
            end
            ks_rd_reg  <= ks_run_reg;
            kd_d_reg   <= key_down_reg[kk_reg];
            kidx_d_reg <= kk_reg;
            if (ks_rd_reg && kd_d_reg && (!best_found_reg || kage < best_age_reg))
            begin
                best_found_reg <= 1'b1;
                best_note_reg  <= kidx_d_reg;
                best_age_reg   <= kage;
            end

            // state update and result staging
            if (op.apply)
            begin
                if (valid_set)
                    voice_valid_reg[wv] <= 1'b1;
                else if (valid_clr)
                    voice_valid_reg[wv] <= 1'b0;
                if (res_valid && !cnt_full)
                begin
                    pend_reg       <= res;
                    pend_valid_reg <= 1'b1;
                    cnt_reg        <= cnt_reg + 1'b1;
                end
            end

            if (op.push)
            begin
                out_reg        <= '{voice_index: pend_reg.voice_index,
                                    action: pend_reg.action,
                                    out_note: pend_reg.out_note,
                                    out_velocity: pend_reg.out_velocity,
                                    last_of_run: op.push_last};
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status = '{
        cmd:        cmd_reg,
        pedal:      pedal_reg,
        vs_done:    !vs_run_reg && !vs_rd_reg,
        ks_done:    !ks_run_reg && !ks_rd_reg,
        need_kscan: mono_reg && found_reg
                    && (cmd_reg == sva_pkg::CMD_NOTE_OFF || cmd_reg == sva_pkg::CMD_PEDAL_UP),
        pend_valid: pend_valid_reg,
        cnt_full:   cnt_full,
        out_free:   out_free,
        kn_done:    kn_reg[sva_pkg::KEY_CNT_W-1],
        sust_hit:   key_sust_reg[kn_reg[sva_pkg::NOTE_W-1:0]]
    };

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/sva_ctrl.sv =====
// sequencing state machine of the voice allocator
`timescale 1ns / 1ps

module sva_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sva_pkg::dp_status_t  status,
    output sva_pkg::ctrl_cmd_t   op
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_VSCAN    = 3'd2;
    localparam logic [2:0] S_KSCAN    = 3'd3;
    localparam logic [2:0] S_APPLY    = 3'd4;
    localparam logic [2:0] S_PEDAL    = 3'd5;
    localparam logic [2:0] S_FINAL    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        op         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op.accept  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.cmd > sva_pkg::CMD_VOICE_DONE
                    || status.cmd == sva_pkg::CMD_PEDAL_DOWN
                    || (status.cmd == sva_pkg::CMD_NOTE_OFF && status.pedal))
                    state_next = S_IDLE;
                else if (status.cmd == sva_pkg::CMD_PEDAL_UP)
                    state_next = S_PEDAL;
                else
                begin
                    op.vscan_start = 1'b1;
                    state_next     = S_VSCAN;
                end
            end
            S_VSCAN:
            begin
                if (status.vs_done)
                begin
                    if (status.need_kscan)
                    begin
                        op.kscan_start = 1'b1;
                        state_next     = S_KSCAN;
                    end
                    else
                        state_next = S_APPLY;
                end
            end
            S_KSCAN:
            begin
                if (status.ks_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (status.pend_valid && !status.cnt_full)
                begin
                    if (status.out_free)
                        op.push = 1'b1;
                end
                else
                begin
                    op.apply   = 1'b1;
                    state_next = (status.cmd == sva_pkg::CMD_PEDAL_UP) ? S_PEDAL : S_FINAL;
                end
            end
            S_PEDAL:
            begin
                op.pedal_step = 1'b1;
                if (status.kn_done)
                    state_next = S_FINAL;
                else if (status.sust_hit)
                    state_next = S_VSCAN;
            end
            S_FINAL:
            begin
                if (!status.pend_valid)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    op.push      = 1'b1;
                    op.push_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/synth_voice_allocator.sv =====
// a note-on or stop takes one voice scan; a mono release also scans the recency memory over all 128 keys
// pedal up walks all 128 keys, each sustained key costing a voice scan (and key scan in mono)
// one request at a time; the next is taken while the last result waits in the output register
// throughput is set by the one-entry-per-cycle scans over voice and recency memories, and by out_stall holding results
// reset clears all control, voice valid bits and key flags; memories need no clearing
`timescale 1ns / 1ps

module synth_voice_allocator #(
    parameter int VOICES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  sva_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output sva_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sva_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           cfg_data
);

    sva_pkg::ctrl_cmd_t  op;
    sva_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    sva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .op       (op)
    );

    sva_datapath #(
        .VOICES (VOICES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
